FILE: rtl/core/dequ_pkg.sv
// Shared definitions for the double-ended queue core: request and status
// codes and the fixed field widths of the stream words.
// No dependencies.
`default_nettype none

package dequ_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Input word: req_type, push_value, read_index, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 40;
  // Output word: status, read_value, entry_count, padded to whole bytes.
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ_AT    = 3'd4
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_ERROR = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/double_ended_queue_core.sv
// Double-ended queue core: a ring buffer in one synchronous memory with a
// head pointer and an entry count, behind stream-style input and output ports.
// Depends on dequ_pkg.
`default_nettype none

// A user sends one request word per item: push to the front, push to the
// back, pop from the front, pop from the back, or read the entry at a
// position counted from the front. Every request returns exactly one word
// carrying a status, a data value and the number of entries held after the
// request. A pop on an empty queue, or a read at a position not below the
// count, returns the error status with zero data and leaves the queue as it
// was. A push onto a full queue is dropped and flagged with the full status.
// Request codes that mean nothing are answered with an ok status, zero data
// and the unchanged count. Pushes store the low DATA_WIDTH bits of
// push_value; results return the stored word zero-extended or cut to 32 bits.
// An accepted request fills a single holding stage, alongside the memory's
// registered read port, and then moves on into the output register; a new
// word is accepted only while the holding stage is empty. A finished result
// may wait in the output register while the next request is accepted. After
// reset the queue is empty; no clearing pass is needed because entries are
// only read once they have been written.
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Fields from bit 0 up: req_type[2:0], push_value[34:3], read_index[38:35],
  // one zero pad bit.
  input  wire logic [dequ_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0 up: status[1:0], read_value[33:2], entry_count[38:34],
  // one zero pad bit.
  output logic      [dequ_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready
);

  import dequ_pkg::*;

  // Pointer and count widths follow from the ring depth.
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // Width used to compare the read position against the count.
  localparam int unsigned IW = (CW > INDEX_W) ? CW : INDEX_W;

  // Request fields.
  logic [REQ_W-1:0]   in_req;
  logic [VALUE_W-1:0] in_value;
  logic [INDEX_W-1:0] in_index;

  assign in_req   = in_tdata[REQ_W-1:0];
  assign in_value = in_tdata[REQ_W+VALUE_W-1:REQ_W];
  assign in_index = in_tdata[REQ_W+VALUE_W+INDEX_W-1:REQ_W+VALUE_W];

  // Queue state.
  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Holding stage between the memory read and the output register.
  logic                s1_vld_r, s1_vld_nxt;
  logic [STATUS_W-1:0] s1_status_r;
  logic                s1_take_r;
  logic [COUNT_W-1:0]  s1_count_r;

  // Output register.
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Memory access signals.
  logic                  wr_en;
  logic [PW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [PW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_q;

  logic          accept;
  logic          s1_move;
  logic          is_full;
  logic          is_empty;
  logic [CW-1:0] cnt_m1;
  logic [PW-1:0] rd_offset;
  logic [63:0]   push_ext;
  logic [63:0]   rd_ext;

  logic [STATUS_W-1:0] req_status;
  logic                req_take;

  // Slot of the entry at a given offset from a base slot, modulo DEPTH.
  // Both inputs are below DEPTH, so one subtraction suffices.
  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                             input logic [PW-1:0] offset);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign accept   = in_tvalid && in_tready;
  assign in_tready = !s1_vld_r;
  assign s1_move  = s1_vld_r && (!out_vld_r || out_tready);

  assign is_full  = (cnt_r == CW'(DEPTH));
  assign is_empty = (cnt_r == '0);
  assign cnt_m1   = cnt_r - CW'(1);

  assign push_ext = 64'(in_value);
  assign wr_data  = push_ext[DATA_WIDTH-1:0];

  // Pop-back reads the last entry, read-at uses the requested position and
  // pop-front reads the head slot itself.
  assign rd_offset = (in_req == REQ_POP_BACK) ? cnt_m1[PW-1:0] :
                     (in_req == REQ_READ_AT)  ? PW'(in_index)  : '0;
  assign rd_addr   = ring_add(head_r, rd_offset);

  // Request decode: status, state update and memory accesses.
  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    req_status = STATUS_OK;
    req_take   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = ring_add(head_r, cnt_r[PW-1:0]);
    rd_en      = 1'b0;
    if (accept) begin
      unique case (in_req)
        REQ_PUSH_FRONT: begin
          if (is_full) begin
            req_status = STATUS_FULL;
          end else begin
            head_nxt = (head_r == '0) ? PW'(DEPTH - 1) : head_r - PW'(1);
            wr_addr  = head_nxt;
            wr_en    = 1'b1;
            cnt_nxt  = cnt_r + CW'(1);
          end
        end
        REQ_PUSH_BACK: begin
          if (is_full) begin
            req_status = STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (is_empty) begin
            req_status = STATUS_ERROR;
          end else begin
            rd_en    = 1'b1;
            req_take = 1'b1;
            head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1);
            cnt_nxt  = cnt_m1;
          end
        end
        REQ_POP_BACK: begin
          if (is_empty) begin
            req_status = STATUS_ERROR;
          end else begin
            rd_en    = 1'b1;
            req_take = 1'b1;
            cnt_nxt  = cnt_m1;
          end
        end
        REQ_READ_AT: begin
          if (IW'(in_index) >= IW'(cnt_r)) begin
            req_status = STATUS_ERROR;
          end else begin
            rd_en    = 1'b1;
            req_take = 1'b1;
          end
        end
        default: begin
          // Unused request codes: no operation.
        end
      endcase
    end
  end

  // Ring memory: one write port, one registered read port. A request never
  // reads and writes in the same cycle, and the read data holds until the
  // next accepted request because nothing else reads the memory.
  logic [DATA_WIDTH-1:0] ring_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= ring_mem[rd_addr];
    end
  end

  assign rd_ext = 64'(rd_q);

  // Valid flags of the holding stage and the output register.
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_move) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s1_move) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      cnt_r     <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= req_status;
      s1_take_r   <= req_take;
      s1_count_r  <= COUNT_W'(cnt_nxt);
    end
    if (s1_move) begin
      out_data_r <= {1'b0, s1_count_r,
                     (s1_take_r ? rd_ext[VALUE_W-1:0] : {VALUE_W{1'b0}}),
                     s1_status_r};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_vld_r;

`ifndef SYNTHESIS
  // The count never exceeds the ring depth.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // The head pointer always names a slot inside the ring.
  assert property (@(posedge clk) disable iff (!rst_n) head_r <= PW'(DEPTH - 1))
    else $error("head pointer outside ring");

  // An accepted request occupies the holding stage in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> s1_vld_r)
    else $error("accepted request lost");

  // A held result stays in the holding stage while the output is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_tready) |=> s1_vld_r)
    else $error("held result dropped under stall");

  // Error and full results carry zero data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_data_r[STATUS_W-1:0] != STATUS_OK))
      |-> (out_data_r[STATUS_W+VALUE_W-1:STATUS_W] == '0))
    else $error("nonzero data with failing status");
`endif

endmodule

`default_nettype wire

FILE: dv/double_ended_queue_core_test.sv
// Self-checking testbench for double_ended_queue_core: directed edge cases, then
// random push, pop and read traffic with stalls on both stream sides.
// Depends on dequ_pkg and the double_ended_queue_core RTL.
`default_nettype none

module double_ended_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dequ_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 12;
  // Cycles without any word moving on either side before the run is called hung.
  localparam int unsigned STALL_LIMIT = 2000;
  // Request codes that the block answers with a plain ok and no change.
  localparam logic [REQ_W-1:0] REQ_FIRST_SPARE = 3'd5;
  localparam logic [REQ_W-1:0] REQ_LAST_SPARE = 3'd7;

  typedef struct packed {
    status_t               status;
    logic [VALUE_W-1:0]    value;
    logic [COUNT_W-1:0]    count;
  } deque_response_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;
  typedef enum int {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_SPARSE} ready_pattern_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;

  // Shadow copy of the queue, advanced once per accepted request word.
  logic [VALUE_W-1:0] shadow_slots [QUEUE_DEPTH];
  logic [3:0] shadow_head = '0;
  logic [COUNT_W-1:0] shadow_count = '0;

  deque_response_t pending_responses [$];
  int error_count = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  double_ended_queue_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Apply one accepted request to the shadow queue and queue up the word
  // the block must answer with. Slot indexes wrap at 16 through 4-bit math.
  function automatic void predict_response(input logic [REQ_W-1:0] kind,
                                           input logic [VALUE_W-1:0] value,
                                           input logic [INDEX_W-1:0] index);
    deque_response_t resp;
    logic [3:0] slot;
    resp.status = STATUS_OK;
    resp.value = '0;
    case (kind)
      REQ_PUSH_FRONT: begin
        if (shadow_count == QUEUE_DEPTH) begin
          resp.status = STATUS_FULL;
        end else begin
          shadow_head = shadow_head - 4'd1;
          shadow_slots[shadow_head] = value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (shadow_count == QUEUE_DEPTH) begin
          resp.status = STATUS_FULL;
        end else begin
          slot = shadow_head + shadow_count[3:0];
          shadow_slots[slot] = value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (shadow_count == 0) begin
          resp.status = STATUS_ERROR;
        end else begin
          resp.value = shadow_slots[shadow_head];
          shadow_head = shadow_head + 4'd1;
          shadow_count = shadow_count - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (shadow_count == 0) begin
          resp.status = STATUS_ERROR;
        end else begin
          slot = shadow_head + shadow_count[3:0] - 4'd1;
          resp.value = shadow_slots[slot];
          shadow_count = shadow_count - 1'b1;
        end
      end
      REQ_READ_AT: begin
        if ({1'b0, index} >= shadow_count) begin
          resp.status = STATUS_ERROR;
        end else begin
          slot = shadow_head + index;
          resp.value = shadow_slots[slot];
        end
      end
      default: begin
        // Spare codes leave the queue alone.
      end
    endcase
    resp.count = shadow_count;
    pending_responses.push_back(resp);
  endfunction

  // Send one request word. The sender runs in bursts; when a burst is used up
  // it holds in_tvalid low for a random gap and then starts a new one.
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [VALUE_W-1:0] value,
                              input logic [INDEX_W-1:0] index);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tdata <= {1'b0, index, value, kind};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_response(kind, value, index);
    burst_left--;
  endtask

  // Stop sending and wait until every answer has come back.
  task automatic drain_responses();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      default: return $urandom();
    endcase
  endfunction

  // An empty queue: both pops and reads must fail, spare codes do nothing.
  task automatic test_empty_queue();
    send_request(REQ_POP_FRONT, 32'h0, 4'd0);
    send_request(REQ_POP_BACK, 32'hFFFF_FFFF, 4'd0);
    send_request(REQ_READ_AT, 32'h0, 4'd15);
    send_request(REQ_FIRST_SPARE, 32'hFFFF_FFFF, 4'd15);
    send_request(REQ_LAST_SPARE, 32'h1234_5678, 4'd0);
  endtask

  // Fill to capacity from both ends, try to overflow both ends, read the
  // last position, and take one word off each end.
  task automatic test_full_queue();
    int n;
    send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
    send_request(REQ_PUSH_FRONT, 32'h0000_0000, 4'd0);
    for (n = 2; n < QUEUE_DEPTH; n++) begin
      send_request((n % 2 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom(), 4'd0);
    end
    send_request(REQ_PUSH_FRONT, 32'hDEAD_BEEF, 4'd0);
    send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF, 4'd15);
    send_request(REQ_READ_AT, 32'h0, 4'd15);
    send_request(REQ_POP_FRONT, 32'h0, 4'd0);
    send_request(REQ_POP_BACK, 32'h0, 4'd0);
  endtask

  // Random requests. The mix swings between filling, draining and balanced
  // traffic so the count sweeps the whole range and wraps the head pointer.
  task automatic test_random_traffic(input int items);
    int n;
    int pick;
    int push_pct;
    int pop_pct;
    traffic_mix_t mix;
    logic [REQ_W-1:0] kind;
    logic [INDEX_W-1:0] index;
    mix = MIX_EVEN;
    push_pct = 35;
    pop_pct = 35;
    for (n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        mix = traffic_mix_t'($urandom_range(0, 2));
        case (mix)
          MIX_FILL: begin
            push_pct = 55;
            pop_pct = 20;
          end
          MIX_DRAIN: begin
            push_pct = 20;
            pop_pct = 55;
          end
          default: begin
            push_pct = 35;
            pop_pct = 35;
          end
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        kind = REQ_W'($urandom_range(REQ_FIRST_SPARE, REQ_LAST_SPARE));
      end else if (pick < 3 + push_pct) begin
        kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      end else if (pick < 3 + push_pct + pop_pct) begin
        kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
      end else begin
        kind = REQ_READ_AT;
      end
      // Most reads land inside the queue; the rest probe any position.
      if (shadow_count != 0 && $urandom_range(0, 3) != 0) begin
        index = INDEX_W'($urandom_range(0, shadow_count - 1));
      end else begin
        index = INDEX_W'($urandom_range(0, 15));
      end
      send_request(kind, pick_value(), index);
    end
  endtask

  // The receiver changes its stall pattern after each stretch of random length:
  // always ready, coin flips, a fixed duty cycle, or mostly stalled.
  initial begin : receiver_pattern
    ready_pattern_t pattern;
    int stretch;
    int period;
    int open_slots;
    int step;
    forever begin
      pattern = ready_pattern_t'($urandom_range(0, 3));
      stretch = $urandom_range(16, 64);
      period = $urandom_range(2, 7);
      open_slots = $urandom_range(1, period - 1);
      for (step = 0; step < stretch; step++) begin
        @(negedge clk);
        case (pattern)
          READY_ALWAYS: out_tready <= 1'b1;
          READY_COIN: out_tready <= ($urandom_range(0, 1) == 1);
          READY_PERIODIC: out_tready <= ((step % period) < open_slots);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Every result word taken from the block is compared with the oldest
  // expectation, field by field.
  always @(posedge clk) begin : check_results
    deque_response_t want;
    logic [STATUS_W-1:0] got_status;
    logic [VALUE_W-1:0] got_value;
    logic [COUNT_W-1:0] got_count;
    if (rst_n && out_tvalid && out_tready) begin
      got_status = out_tdata[1:0];
      got_value = out_tdata[33:2];
      got_count = out_tdata[38:34];
      if (pending_responses.size() == 0) begin
        $display("%0t: result word with nothing pending, got %h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        if (got_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, got_status);
          error_count++;
        end
        if (got_value !== want.value) begin
          $display("%0t: read_value expected %h, got %h", $time, want.value, got_value);
          error_count++;
        end
        if (got_count !== want.count) begin
          $display("%0t: entry_count expected %0d, got %0d", $time, want.count, got_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: no word accepted on either side for too long means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("double_ended_queue_core_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_full_queue();
    drain_responses();
    test_random_traffic(312);
    // Let the queue run dry of answers before the second random phase.
    drain_responses();
    test_random_traffic(312);
    drain_responses();

    // A final wait catches any stray result word.
    repeat (6) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_responses.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("double_ended_queue_core_test: clean");
    end else begin
      $display("double_ended_queue_core_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/dequ_pkg.sv
rtl/core/double_ended_queue_core.sv
dv/double_ended_queue_core_test.sv
